// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must imply another condition in the same cycle.
`define ASSERT_IMPLIES(lbl, cond, expr, msg) \
   `ASSERT_CLK(lbl, (cond) |-> (expr), msg)

`endif

// File: src/mqttfhd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT fixed header deframer package
// Phase codes, byte roles, status codes and shared types.
// ----------------------------------------------------------------------------
package mqttfhd_pkg;

   localparam int unsigned LEN_W = 28;
   localparam int unsigned TOTAL_W = 29;
   localparam int unsigned CNT_W = 3;

   // Phase codes of the framing state machine.
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_LOCKED = 2'd3;

   // Byte roles.
   localparam logic [1:0] ROLE_HEADER = 2'd0;
   localparam logic [1:0] ROLE_LENGTH = 2'd1;
   localparam logic [1:0] ROLE_BODY   = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_LEN_BYTES = 2'd1;
   localparam logic [1:0] STAT_BOUNDS    = 2'd2;
   localparam logic [1:0] STAT_UNKNOWN   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_MIN_LEN = 1'b0;
   localparam logic CSR_MAX_LEN = 1'b1;

   localparam logic [TOTAL_W-1:0] MIN_LEN_RESET = 29'd2;
   localparam logic [TOTAL_W-1:0] MAX_LEN_RESET = 29'd268435460;

   localparam logic [CNT_W-1:0] LEN_MAX_BYTES = 3'd4;

   // Result of folding one length byte into the accumulated length.
   typedef struct packed {
      logic [LEN_W-1:0] accum;
      logic [CNT_W-1:0] count;
      logic             more;
      logic             out_of_bounds;
      logic             zero;
   } len_step_type;

endpackage

// File: src/mqttfhd_len_step.sv
// ----------------------------------------------------------------------------
// MQTT remaining length step
// Folds one varint byte into the remaining length and checks the total
// packet length against the configured bounds.
// ----------------------------------------------------------------------------
module mqttfhd_len_step (
   input  logic [mqttfhd_pkg::LEN_W-1:0]   accum,
   input  logic [mqttfhd_pkg::CNT_W-1:0]   count,
   input  logic [7:0]                      data_byte,
   input  logic [mqttfhd_pkg::TOTAL_W-1:0] min_len,
   input  logic [mqttfhd_pkg::TOTAL_W-1:0] max_len,
   output mqttfhd_pkg::len_step_type       step
);
   import mqttfhd_pkg::*;

   logic [6:0]         group;
   logic [LEN_W-1:0]   shifted;
   logic [LEN_W-1:0]   new_accum;
   logic [CNT_W-1:0]   new_count;
   logic [TOTAL_W-1:0] total;

   assign group = data_byte[6:0];

   // Least significant group first; only counts below four reach here.
   always_comb begin
      case (count)
         3'd0:    shifted = {21'd0, group};
         3'd1:    shifted = {14'd0, group, 7'd0};
         3'd2:    shifted = {7'd0, group, 14'd0};
         default: shifted = {group, 21'd0};
      endcase
   end

   assign new_accum = accum | shifted;
   assign new_count = count + 3'd1;
   assign total     = 29'd1 + {26'd0, new_count} + {1'b0, new_accum};

   assign step.accum         = new_accum;
   assign step.count         = new_count;
   assign step.more          = data_byte[7];
   assign step.out_of_bounds = (total < min_len) || (total > max_len);
   assign step.zero          = (new_accum == '0);

endmodule

// File: src/mqtt_fixed_header_deframer_top.sv
// ----------------------------------------------------------------------------
// MQTT fixed header deframer
// A word accepted at an edge sits in the result register right after that edge
// and is held there until taken.
// Throughput: one word per cycle, with no bubble while results are taken.
// Reset clears the phase, the counters and the result valid, and restores the
// default length bounds. After an error all words are taken and dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqtt_fixed_header_deframer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic [3:0]                      rsp_packet_type,
   output logic [3:0]                      rsp_header_flags,
   output logic [1:0]                      rsp_byte_role,
   output logic [mqttfhd_pkg::LEN_W-1:0]   rsp_remaining_len,
   output logic                            rsp_last,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_write_en,
   input  logic                            csr_index,
   input  logic [mqttfhd_pkg::TOTAL_W-1:0] csr_wdata
);
   import mqttfhd_pkg::*;

   logic [TOTAL_W-1:0] min_len_ff, min_len_in;
   logic [TOTAL_W-1:0] max_len_ff, max_len_in;
   logic [1:0]         phase_ff, phase_in;
   logic [7:0]         header_ff, header_in;
   logic [LEN_W-1:0]   accum_ff, accum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   body_left_ff, body_left_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [7:0]         rsp_header_ff, rsp_header_in;
   logic [1:0]         rsp_role_ff, rsp_role_in;
   logic [LEN_W-1:0]   rsp_rem_ff, rsp_rem_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               type_unknown;
   logic [LEN_W-1:0]   body_dec;
   len_step_type       step;
   logic               rsp_error;
   logic               rsp_header_word;

   mqttfhd_len_step u_len_step (
      .accum     (accum_ff),
      .count     (count_ff),
      .data_byte (req_data_byte),
      .min_len   (min_len_ff),
      .max_len   (max_len_ff),
      .step      (step)
   );

   // The result register frees up when its word is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign type_unknown = (header_ff[7:4] == 4'd0) || (header_ff[7:4] == 4'd15);
   assign body_dec     = (body_left_ff != '0) ? body_left_ff - 28'd1 : '0;

   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_LEN: min_len_in = csr_wdata;
            default:     max_len_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      header_in     = header_ff;
      accum_in      = accum_ff;
      count_in      = count_ff;
      body_left_in  = body_left_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_header_in = rsp_header_ff;
      rsp_role_in   = rsp_role_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (req_fire && phase_ff != PH_LOCKED) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = req_data_byte;
         rsp_header_in = header_ff;
         rsp_rem_in    = accum_ff;
         rsp_last_in   = 1'b0;
         rsp_status_in = STAT_OK;

         unique case (phase_ff)
            PH_HEADER: begin
               header_in     = req_data_byte;
               rsp_header_in = req_data_byte;
               accum_in      = '0;
               count_in      = '0;
               body_left_in  = '0;
               rsp_role_in   = ROLE_HEADER;
               rsp_rem_in    = '0;
               phase_in      = PH_LENGTH;
            end
            PH_LENGTH: begin
               rsp_role_in = ROLE_LENGTH;
               if (count_ff >= LEN_MAX_BYTES) begin
                  // A fifth length byte is a framing error.
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STAT_LEN_BYTES;
                  phase_in      = PH_LOCKED;
               end else begin
                  accum_in   = step.accum;
                  count_in   = step.count;
                  rsp_rem_in = step.accum;
                  if (!step.more) begin
                     if (step.out_of_bounds) begin
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STAT_BOUNDS;
                        phase_in      = PH_LOCKED;
                     end else if (step.zero) begin
                        rsp_last_in = 1'b1;
                        if (type_unknown) begin
                           rsp_status_in = STAT_UNKNOWN;
                           phase_in      = PH_LOCKED;
                        end else begin
                           phase_in = PH_HEADER;
                        end
                     end else begin
                        body_left_in = step.accum;
                        phase_in     = PH_BODY;
                     end
                  end
               end
            end
            PH_BODY: begin
               rsp_role_in  = ROLE_BODY;
               body_left_in = body_dec;
               if (body_dec == '0) begin
                  rsp_last_in = 1'b1;
                  if (type_unknown) begin
                     rsp_status_in = STAT_UNKNOWN;
                     phase_in      = PH_LOCKED;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            default: begin
               phase_in = PH_LOCKED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_LEN_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         phase_ff     <= PH_HEADER;
         header_ff    <= '0;
         accum_ff     <= '0;
         count_ff     <= '0;
         body_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_len_ff   <= min_len_in;
         max_len_ff   <= max_len_in;
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         accum_ff     <= accum_in;
         count_ff     <= count_in;
         body_left_ff <= body_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_header_ff <= rsp_header_in;
      rsp_role_ff   <= rsp_role_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_packet_type   = rsp_header_ff[7:4];
   assign rsp_header_flags  = rsp_header_ff[3:0];
   assign rsp_byte_role     = rsp_role_ff;
   assign rsp_remaining_len = rsp_rem_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_status        = rsp_status_ff;

   assign rsp_error       = rsp_valid_ff && (rsp_status_ff != STAT_OK);
   assign rsp_header_word = rsp_valid_ff && (rsp_role_ff == ROLE_HEADER);

   `ASSERT_IMPLIES(a_error_is_last, rsp_error, rsp_last_ff, "error word without last")
   `ASSERT_IMPLIES(a_error_locks, rsp_error, phase_ff == PH_LOCKED, "error without lock")
   `ASSERT_IMPLIES(a_body_nonzero, phase_ff == PH_BODY, body_left_ff != '0, "empty body phase")
   `ASSERT_IMPLIES(a_len_count, phase_ff == PH_LENGTH, count_ff <= LEN_MAX_BYTES, "count overran")
   `ASSERT_IMPLIES(a_header_word, rsp_header_word, {rsp_last_ff, rsp_rem_ff} == '0, "bad header")

endmodule

// File: tb/mqtt_fixed_header_deframer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MQTT fixed header deframer testbench
// Feeds byte streams of well-formed MQTT packets under several length bounds,
// with random idle cycles on both handshakes and one long output stall. Each
// result word is checked against a table entry or an in-bench framing predictor.
// The run ends with one randomly chosen error case, then more bytes that must be dropped.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer_top_test;

   import mqttfhd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned CHUNK_WORDS   = 85;
   localparam int unsigned LONG_HOLD     = 400;

   // Stimulus table groups: the opening sequence and the closing error cases.
   localparam logic [3:0] SCEN_DIRECTED      = 4'd0;
   localparam logic [3:0] SCEN_LEN_BYTES     = 4'd1;
   localparam logic [3:0] SCEN_OVER_MAX      = 4'd2;
   localparam logic [3:0] SCEN_MIN_OVER_MAX  = 4'd3;
   localparam logic [3:0] SCEN_BODY_UNKNOWN  = 4'd4;
   localparam logic [3:0] SCEN_ZERO_UNKNOWN  = 4'd5;
   localparam logic [3:0] SCEN_UNDER_MIN     = 4'd6;

   localparam logic [LEN_W-1:0] LEN_ALL_ONES = 28'hFFFFFFF;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [3:0]       packet_type;
      logic [3:0]       header_flags;
      logic [1:0]       byte_role;
      logic [LEN_W-1:0] remaining_len;
      logic             last;
      logic [1:0]       status;
   } frame_word_type;

   typedef struct packed {
      logic [3:0]     scen;
      logic [7:0]     data_byte;
      logic           has_exp;
      frame_word_type exp_word;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic [3:0]         rsp_packet_type;
   logic [3:0]         rsp_header_flags;
   logic [1:0]         rsp_byte_role;
   logic [LEN_W-1:0]   rsp_remaining_len;
   logic               rsp_last;
   logic [1:0]         rsp_status;
   logic               csr_write_en = 1'b0;
   logic               csr_index = CSR_MIN_LEN;
   logic [TOTAL_W-1:0] csr_wdata = '0;

   // Framing state tracked by the bench.
   logic [1:0]         exp_phase = PH_HEADER;
   logic [7:0]         exp_header = 8'd0;
   logic [LEN_W-1:0]   exp_len_acc = '0;
   logic [CNT_W-1:0]   exp_len_bytes = '0;
   logic [LEN_W-1:0]   exp_body_left = '0;
   logic [TOTAL_W-1:0] exp_min_len = MIN_LEN_RESET;
   logic [TOTAL_W-1:0] exp_max_len = MAX_LEN_RESET;

   frame_word_type     pending_frames[$];
   stim_row_type       stim_rows[$];

   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   int unsigned        words_sent = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count = 0;
   bit                 long_hold_req = 1'b0;
   bit                 long_hold_started = 1'b0;
   int unsigned        hold_left = 0;

   mqtt_fixed_header_deframer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_header_flags  (rsp_header_flags),
      .rsp_byte_role     (rsp_byte_role),
      .rsp_remaining_len (rsp_remaining_len),
      .rsp_last          (rsp_last),
      .rsp_status        (rsp_status),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End of a well-framed packet: an unknown type locks the stream.
   function automatic logic [1:0] close_packet();
      if (exp_header[7:4] == 4'd0 || exp_header[7:4] == 4'hF) begin
         exp_phase = PH_LOCKED;
         return STAT_UNKNOWN;
      end
      exp_phase = PH_HEADER;
      return STAT_OK;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, output logic produced,
                               output frame_word_type w);
      logic [LEN_W-1:0] grp;
      int unsigned      total;
      w = '0;
      produced = 1'b0;
      if (exp_phase == PH_LOCKED) return;
      produced = 1'b1;
      w.out_byte = b;
      w.byte_role = ROLE_HEADER;
      case (exp_phase)
         PH_HEADER: begin
            exp_header = b;
            exp_len_acc = '0;
            exp_len_bytes = '0;
            exp_body_left = '0;
            exp_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            w.byte_role = ROLE_LENGTH;
            if (exp_len_bytes >= LEN_MAX_BYTES) begin
               w.remaining_len = exp_len_acc;
               w.last = 1'b1;
               w.status = STAT_LEN_BYTES;
               exp_phase = PH_LOCKED;
            end else begin
               grp = {21'd0, b[6:0]};
               exp_len_acc = exp_len_acc | (grp << (7 * exp_len_bytes));
               exp_len_bytes = exp_len_bytes + 3'd1;
               w.remaining_len = exp_len_acc;
               if (!b[7]) begin
                  total = 32'd1 + 32'(exp_len_bytes) + 32'(exp_len_acc);
                  if (total < exp_min_len || total > exp_max_len) begin
                     w.last = 1'b1;
                     w.status = STAT_BOUNDS;
                     exp_phase = PH_LOCKED;
                  end else if (exp_len_acc == '0) begin
                     w.last = 1'b1;
                     w.status = close_packet();
                  end else begin
                     exp_body_left = exp_len_acc;
                     exp_phase = PH_BODY;
                  end
               end
            end
         end
         default: begin
            w.byte_role = ROLE_BODY;
            w.remaining_len = exp_len_acc;
            if (exp_body_left != '0) exp_body_left = exp_body_left - 28'd1;
            if (exp_body_left == '0) begin
               w.last = 1'b1;
               w.status = close_packet();
            end
         end
      endcase
      w.packet_type = exp_header[7:4];
      w.header_flags = exp_header[3:0];
   endtask

   task automatic add_row(input logic [3:0] scen, input logic [7:0] b);
      stim_row_type row;
      row = '0;
      row.scen = scen;
      row.data_byte = b;
      stim_rows.push_back(row);
   endtask

   task automatic add_expect(input logic [3:0] scen, input logic [7:0] b,
                             input logic [3:0] ptype, input logic [3:0] flags,
                             input logic [1:0] role, input logic [LEN_W-1:0] rem,
                             input logic last, input logic [1:0] status);
      stim_row_type row;
      row.scen = scen;
      row.data_byte = b;
      row.has_exp = 1'b1;
      row.exp_word = {b, ptype, flags, role, rem, last, status};
      stim_rows.push_back(row);
   endtask

   task automatic send_word(input logic [7:0] b, input logic has_exp,
                            input frame_word_type typed_word);
      logic           produced;
      frame_word_type want;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      deframe_byte(b, produced, want);
      if (produced) pending_frames.push_back(has_exp ? typed_word : want);
      words_sent++;
   endtask

   task automatic run_scenario(input logic [3:0] scen);
      for (int i = 0; i < stim_rows.size(); i++)
         if (stim_rows[i].scen == scen)
            send_word(stim_rows[i].data_byte, stim_rows[i].has_exp, stim_rows[i].exp_word);
   endtask

   // Picks a length byte count and remaining length that fit the current bounds,
   // padding the length field with zero groups where more bytes are chosen.
   task automatic send_random_packet();
      int unsigned nlen;
      int unsigned lo;
      int unsigned hi;
      int unsigned rem;
      int unsigned span;
      bit          found;
      logic [7:0]  hdr;
      logic [7:0]  lb;
      found = 1'b0;
      nlen = 1;
      lo = 0;
      while (!found) begin
         nlen = $urandom_range(4, 1);
         lo = (exp_min_len > 1 + nlen) ? exp_min_len - 1 - nlen : 0;
         found = (exp_max_len >= 1 + nlen + lo) && (lo < (1 << (7 * nlen)));
      end
      hi = exp_max_len - 1 - nlen;
      span = ($urandom_range(9, 0) == 0) ? 200 : 12;
      if (hi - lo > span) hi = lo + span;
      if (hi >= (1 << (7 * nlen))) hi = (1 << (7 * nlen)) - 1;
      rem = $urandom_range(hi, lo);
      hdr[7:4] = 4'($urandom_range(14, 1));
      hdr[3:0] = 4'($urandom_range(15, 0));
      send_word(hdr, 1'b0, '0);
      for (int i = 0; i < nlen; i++) begin
         lb = 8'((rem >> (7 * i)) & 32'h7F);
         lb[7] = (i + 1 < nlen);
         send_word(lb, 1'b0, '0);
      end
      for (int i = 0; i < rem; i++) send_word(8'($urandom_range(255, 0)), 1'b0, '0);
   endtask

   task automatic write_len_bounds(input logic [TOTAL_W-1:0] lo,
                                   input logic [TOTAL_W-1:0] hi);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MIN_LEN;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= hi;
      @(posedge clock);
      csr_write_en <= 1'b0;
      exp_min_len = lo;
      exp_max_len = hi;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Output side: random stalls, plus one long hold that lets the block back up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_started) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         long_hold_started <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      frame_word_type got;
      frame_word_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_byte, rsp_packet_type, rsp_header_flags, rsp_byte_role,
                rsp_remaining_len, rsp_last, rsp_status};
         if (pending_frames.size() == 0) begin
            if (mismatch_count < 10)
               $display("extra: byte %h type %h flags %h role %0d len %0d last %b st %0d",
                        got.out_byte, got.packet_type, got.header_flags, got.byte_role,
                        got.remaining_len, got.last, got.status);
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            if (got.out_byte !== want.out_byte || got.packet_type !== want.packet_type ||
                got.header_flags !== want.header_flags || got.byte_role !== want.byte_role ||
                got.remaining_len !== want.remaining_len || got.last !== want.last ||
                got.status !== want.status) begin
               if (mismatch_count < 10) begin
                  $display("exp: byte %h type %h flags %h role %0d len %0d last %b st %0d",
                           want.out_byte, want.packet_type, want.header_flags,
                           want.byte_role, want.remaining_len, want.last, want.status);
                  $display("got: byte %h type %h flags %h role %0d len %0d last %b st %0d",
                           got.out_byte, got.packet_type, got.header_flags,
                           got.byte_role, got.remaining_len, got.last, got.status);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic [3:0]         closing;
      logic [TOTAL_W-1:0] lo;
      logic [TOTAL_W-1:0] hi;

      // Opening sequence: first word after reset, zero-length packets, a padded
      // four-byte length, and extremes of the header nibbles.
      add_expect(SCEN_DIRECTED, 8'h10, 4'h1, 4'h0, ROLE_HEADER, '0, 1'b0, STAT_OK);
      add_expect(SCEN_DIRECTED, 8'h00, 4'h1, 4'h0, ROLE_LENGTH, '0, 1'b1, STAT_OK);
      add_expect(SCEN_DIRECTED, 8'hEF, 4'hE, 4'hF, ROLE_HEADER, '0, 1'b0, STAT_OK);
      add_row(SCEN_DIRECTED, 8'h80);
      add_row(SCEN_DIRECTED, 8'h80);
      add_row(SCEN_DIRECTED, 8'h80);
      add_expect(SCEN_DIRECTED, 8'h00, 4'hE, 4'hF, ROLE_LENGTH, '0, 1'b1, STAT_OK);
      add_row(SCEN_DIRECTED, 8'h3F);
      add_row(SCEN_DIRECTED, 8'h83);
      add_row(SCEN_DIRECTED, 8'h80);
      add_row(SCEN_DIRECTED, 8'h80);
      add_row(SCEN_DIRECTED, 8'h00);
      add_row(SCEN_DIRECTED, 8'h00);
      add_row(SCEN_DIRECTED, 8'hFF);
      add_row(SCEN_DIRECTED, 8'hA5);
      add_row(SCEN_DIRECTED, 8'h82);
      add_row(SCEN_DIRECTED, 8'h02);
      add_row(SCEN_DIRECTED, 8'h55);
      add_row(SCEN_DIRECTED, 8'hAA);
      add_row(SCEN_DIRECTED, 8'h71);
      add_row(SCEN_DIRECTED, 8'h81);
      add_row(SCEN_DIRECTED, 8'h00);
      add_row(SCEN_DIRECTED, 8'h7E);

      // Closing error cases; only one can run, since an error locks until reset.
      add_row(SCEN_LEN_BYTES, 8'h5A);
      repeat (4) add_row(SCEN_LEN_BYTES, 8'hFF);
      add_expect(SCEN_LEN_BYTES, 8'h01, 4'h5, 4'hA, ROLE_LENGTH, LEN_ALL_ONES, 1'b1,
                 STAT_LEN_BYTES);
      add_row(SCEN_OVER_MAX, 8'h9C);
      repeat (3) add_row(SCEN_OVER_MAX, 8'hFF);
      add_expect(SCEN_OVER_MAX, 8'h7F, 4'h9, 4'hC, ROLE_LENGTH, LEN_ALL_ONES, 1'b1,
                 STAT_BOUNDS);
      add_row(SCEN_MIN_OVER_MAX, 8'hF3);
      add_expect(SCEN_MIN_OVER_MAX, 8'h00, 4'hF, 4'h3, ROLE_LENGTH, '0, 1'b1, STAT_BOUNDS);
      add_row(SCEN_BODY_UNKNOWN, 8'h0B);
      add_row(SCEN_BODY_UNKNOWN, 8'h02);
      add_row(SCEN_BODY_UNKNOWN, 8'h11);
      add_expect(SCEN_BODY_UNKNOWN, 8'h22, 4'h0, 4'hB, ROLE_BODY, 28'd2, 1'b1, STAT_UNKNOWN);
      add_row(SCEN_ZERO_UNKNOWN, 8'hF0);
      add_expect(SCEN_ZERO_UNKNOWN, 8'h00, 4'hF, 4'h0, ROLE_LENGTH, '0, 1'b1, STAT_UNKNOWN);
      add_row(SCEN_UNDER_MIN, 8'h47);
      add_expect(SCEN_UNDER_MIN, 8'h03, 4'h4, 4'h7, ROLE_LENGTH, 28'd3, 1'b1, STAT_BOUNDS);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_len_bounds(MIN_LEN_RESET, MAX_LEN_RESET);
      send_idle_pct = 10;
      recv_idle_pct = 64;
      run_scenario(SCEN_DIRECTED);
      drain();

      for (int c = 0; c < 6; c++) begin
         case (c)
            0: begin lo = MIN_LEN_RESET; hi = MAX_LEN_RESET; end
            1: begin lo = 29'd5;         hi = 29'd5;         end
            2: begin lo = 29'd10;        hi = 29'd40;        end
            3: begin lo = 29'd2;         hi = 29'd2;         end
            4: begin lo = 29'd2;         hi = 29'h0FFFFFFF;  end
            default: begin lo = 29'd150; hi = MAX_LEN_RESET; end
         endcase
         if (c < 2) begin
            send_idle_pct = 10;
            recv_idle_pct = 64;
         end else if (c < 4) begin
            send_idle_pct = 64;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_len_bounds(lo, hi);
         if (c == 1) long_hold_req = 1'b1;
         words_sent = 0;
         while (words_sent < CHUNK_WORDS) send_random_packet();
         drain();
      end

      closing = 4'($urandom_range(6, 1));
      case (closing)
         SCEN_OVER_MAX:     write_len_bounds(MIN_LEN_RESET, MAX_LEN_RESET - 29'd1);
         SCEN_MIN_OVER_MAX: write_len_bounds(MAX_LEN_RESET, MIN_LEN_RESET);
         SCEN_UNDER_MIN:    write_len_bounds(29'd20, MAX_LEN_RESET);
         default:           write_len_bounds(MIN_LEN_RESET, MAX_LEN_RESET);
      endcase
      run_scenario(closing);
      // The block is locked now: these words are taken and dropped.
      repeat (20) send_word(8'($urandom_range(255, 0)), 1'b0, '0);
      drain();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && pending_frames.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/mqttfhd_pkg.sv
src/mqttfhd_len_step.sv
src/mqtt_fixed_header_deframer_top.sv
tb/mqtt_fixed_header_deframer_top_test.sv
